// File: rtl/lpg_pkg.sv
// Package for the line pixel generator: widths, command codes and the
// payload, queue-entry and queue-status struct types.
// No dependencies; every other file uses this package.
`timescale 1ns / 1ps

package lpg_pkg;

   // Coordinate width; the derived widths hold every value a line can reach.
   localparam int COORD_BITS = 12;
   localparam int FLAT_BITS  = COORD_BITS + 2;     // 2H
   localparam int DIAG_BITS  = COORD_BITS + 3;     // 2(H - W)
   localparam int ERR_BITS   = 2 * COORD_BITS + 4; // decision variable

   // Queue between front and back; depth must be a power of two, at least 2.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   typedef struct packed {
      logic                  command;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] end_x_in;
      logic [COORD_BITS-1:0] end_y_in;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic                  last_pixel;
   } rsp_type;

   // Decoded item as held in the queue
   typedef struct packed {
      logic                  is_step;
      logic                  draws;      // start: more pixels follow
      logic [COORD_BITS-1:0] first_x;
      logic [COORD_BITS-1:0] first_y;
      logic [COORD_BITS-1:0] last_x;
      logic [ERR_BITS-1:0]   err_init;
      logic [FLAT_BITS-1:0]  flat_inc;
      logic [DIAG_BITS-1:0]  diag_inc;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type work;
   } q_head_type;

endpackage

// File: rtl/lpg_front.sv
// Front end of the line pixel generator: orders the endpoints of a start
// transfer and works out the Bresenham increments and initial error term.
// Depends on lpg_pkg.
`timescale 1ns / 1ps

module lpg_front (
   input  lpg_pkg::req_type  req_data,
   output lpg_pkg::work_type work
);

   localparam int C = lpg_pkg::COORD_BITS;

   logic                           swap;
   logic [C-1:0]                   x0, y0, x1, y1;
   logic [C-1:0]                   w;
   logic [C:0]                     h;
   logic [lpg_pkg::FLAT_BITS-1:0]  flat;
   logic [lpg_pkg::FLAT_BITS-1:0]  h_minus_w;
   logic [lpg_pkg::DIAG_BITS-1:0]  err_short;

   always_comb begin
      swap = (req_data.start_x >= req_data.end_x_in);
      x0   = swap ? req_data.end_x_in : req_data.start_x;
      y0   = swap ? req_data.end_y_in : req_data.start_y;
      x1   = swap ? req_data.start_x  : req_data.end_x_in;
      y1   = swap ? req_data.start_y  : req_data.end_y_in;

      // x1 >= x0 after ordering, so W is never negative
      w         = x1 - x0;
      h         = {1'b0, y1} - {1'b0, y0};
      flat      = {h, 1'b0};
      h_minus_w = {h[C], h} - {2'b00, w};
      err_short = {flat[lpg_pkg::FLAT_BITS-1], flat} - {3'b000, w};

      work.is_step  = (req_data.command == lpg_pkg::CMD_STEP);
      work.draws    = (req_data.start_x != req_data.end_x_in);
      work.first_x  = x0;
      work.first_y  = y0;
      work.last_x   = x1;
      work.flat_inc = flat;
      work.diag_inc = {h_minus_w, 1'b0};
      work.err_init = {{(lpg_pkg::ERR_BITS - lpg_pkg::DIAG_BITS)
                        {err_short[lpg_pkg::DIAG_BITS-1]}}, err_short};
   end

endmodule

// File: rtl/lpg_queue.sv
// Short queue of decoded items between the front and back ends.
// Depends on lpg_pkg.
`timescale 1ns / 1ps

module lpg_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  lpg_pkg::work_type      push_work,
   output logic                   full,
   input  logic                   pop,
   output lpg_pkg::q_head_type    head
);

   lpg_pkg::work_type              entry_ff [lpg_pkg::QUEUE_DEPTH];
   logic [lpg_pkg::QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [lpg_pkg::QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [lpg_pkg::QCNT_BITS-1:0]  count_ff, count_in;
   logic                           push;
   logic                           take;

   always_comb begin
      full       = (count_ff == lpg_pkg::QCNT_BITS'(lpg_pkg::QUEUE_DEPTH));
      head.valid = (count_ff != '0);
      head.work  = entry_ff[rd_ptr_ff];
      push       = push_valid && !full;
      take       = pop && head.valid;

      // pointers wrap on their own, depth being a power of two
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_work;
      end
   end

endmodule

// File: rtl/lpg_engine.sv
// Back end of the line pixel generator: holds the line state, runs one
// Bresenham step per step item while drawing and drives the registered result channel.
// Depends on lpg_pkg.
`timescale 1ns / 1ps

module lpg_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  lpg_pkg::q_head_type  head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lpg_pkg::rsp_type     rsp_data
);

   localparam int C = lpg_pkg::COORD_BITS;
   localparam int E = lpg_pkg::ERR_BITS;

   logic [C-1:0]                  cur_x_ff, cur_x_in;
   logic [C-1:0]                  cur_y_ff, cur_y_in;
   logic [C-1:0]                  stop_x_ff, stop_x_in;
   logic [E-1:0]                  err_ff, err_in;
   logic [lpg_pkg::FLAT_BITS-1:0] flat_ff, flat_in;
   logic [lpg_pkg::DIAG_BITS-1:0] diag_ff, diag_in;
   logic                          drawing_ff, drawing_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   lpg_pkg::rsp_type              rsp_data_ff, rsp_data_in;
   logic                          out_free;
   logic                          emit;
   logic [C-1:0]                  step_x;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      pop      = head.valid && out_free;
      step_x   = cur_x_ff + 1'b1;

      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      stop_x_in   = stop_x_ff;
      err_in      = err_ff;
      flat_in     = flat_ff;
      diag_in     = diag_ff;
      drawing_in  = drawing_ff;
      emit        = 1'b0;
      rsp_data_in = rsp_data_ff;

      if (pop && !head.work.is_step) begin
         cur_x_in    = head.work.first_x;
         cur_y_in    = head.work.first_y;
         stop_x_in   = head.work.last_x;
         err_in      = head.work.err_init;
         flat_in     = head.work.flat_inc;
         diag_in     = head.work.diag_inc;
         drawing_in  = head.work.draws;
         emit        = 1'b1;
         rsp_data_in = '{pixel_x: head.work.first_x, pixel_y: head.work.first_y,
                         last_pixel: !head.work.draws};
      end else if (pop && drawing_ff) begin
         // a step while idle is dropped
         if (err_ff[E-1]) begin
            err_in = err_ff + {{(E - lpg_pkg::FLAT_BITS){flat_ff[lpg_pkg::FLAT_BITS-1]}},
                               flat_ff};
         end else begin
            err_in   = err_ff + {{(E - lpg_pkg::DIAG_BITS){diag_ff[lpg_pkg::DIAG_BITS-1]}},
                                 diag_ff};
            cur_y_in = cur_y_ff + 1'b1;
         end
         cur_x_in    = step_x;
         drawing_in  = (step_x != stop_x_ff);
         emit        = 1'b1;
         rsp_data_in = '{pixel_x: step_x, pixel_y: cur_y_in,
                         last_pixel: (step_x == stop_x_ff)};
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         stop_x_ff    <= '0;
         err_ff       <= '0;
         flat_ff      <= '0;
         diag_ff      <= '0;
         drawing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         stop_x_ff    <= stop_x_in;
         err_ff       <= err_in;
         flat_ff      <= flat_in;
         diag_ff      <= diag_in;
         drawing_ff   <= drawing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/line_pixel_generator.sv
// Top level of the line pixel generator: front end, decoded-item queue and
// back end wired together. Depends on lpg_pkg, lpg_front, lpg_queue, lpg_engine.
`timescale 1ns / 1ps
//
//   channel   ports                         direction   payload
//   request   req_valid/req_stall/req_data  in          command + two endpoints
//   response  rsp_valid/rsp_stall/rsp_data  out         pixel x/y + last flag
//
// One request per clock is taken while the queue is not full; a start or a step
// while drawing gives one response, a step while idle gives none.
// With no stalls a request passes the queue write and then the back end's output
// register; the Bresenham step is one add and compare.
// Reset (synchronous, active high) empties the queue and leaves the line idle.
// req_stall is the queue-full flag, so the front keeps taking transfers while a
// result waits on rsp_stall, until the queue is full.

module line_pixel_generator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lpg_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lpg_pkg::rsp_type  rsp_data
);

   lpg_pkg::work_type    work;   // decoded request
   lpg_pkg::q_head_type  head;   // oldest queued item
   logic                 pop;

   // front: endpoint ordering and increment set-up
   lpg_front u_front (
      .req_data (req_data),
      .work     (work)
   );

   // queue: lets front and back stall independently
   lpg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_work  (work),
      .full       (req_stall),
      .pop        (pop),
      .head       (head)
   );

   // back: line state, stepping and result register
   lpg_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/lpg_checker.sv
// Port-level checks for the line pixel generator, bound to the top level.
// Depends on lpg_pkg and line_pixel_generator.
`timescale 1ns / 1ps

module lpg_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lpg_pkg::rsp_type  rsp_data
);

   // a stalled result is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response dropped or changed");

   // the queue only fills through a request transfer
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall))
      else $error("request stall raised without a transfer");

   // reset leaves the block empty and ready
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   // the queue only fills behind a response held by the receiver
   a_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("queue filled while the response side was free");

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker (.*);
